[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TSNI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsni assertion failed");

// Next-cycle implication, disabled while in reset.
`define TSNI_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsni assertion failed");

`endif

[rtl/tsni_pkg.sv]
// Types and constants for the TLS server-name extractor.
package tsni_pkg;

    localparam int unsigned POSITION_BITS_DEF  = 18;
    localparam int unsigned RESULT_DEPTH       = 4;

    localparam logic [7:0]  CONTENT_HANDSHAKE  = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO    = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME    = 16'h0000;

    localparam int unsigned REC_HEADER_LEN     = 5;
    localparam int unsigned HS_HEADER_LEN      = 9;
    localparam int unsigned VERSION_RANDOM_LEN = 2 + 32;
    localparam int unsigned SESSION_ID_POS     = HS_HEADER_LEN + VERSION_RANDOM_LEN;
    // From the low type byte: ext length (2), list length (2), entry type (1).
    localparam int unsigned SNI_NAME_LEN_OFS   = 6;
    localparam int unsigned SNI_MIN_END_OFS    = 8;
    localparam int unsigned EXT_HEADER_LEN     = 4;

    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [14:0] {
        PH_HEADER    = 15'b000000000000001,
        PH_CIPHER_HI = 15'b000000000000010,
        PH_CIPHER_LO = 15'b000000000000100,
        PH_COMP_LEN  = 15'b000000000001000,
        PH_EXT_HI    = 15'b000000000010000,
        PH_EXT_LO    = 15'b000000000100000,
        PH_TYPE_HI   = 15'b000000001000000,
        PH_TYPE_LO   = 15'b000000010000000,
        PH_LEN_HI    = 15'b000000100000000,
        PH_LEN_LO    = 15'b000001000000000,
        PH_NAME_HI   = 15'b000010000000000,
        PH_NAME_LO   = 15'b000100000000000,
        PH_NAME      = 15'b001000000000000,
        PH_DONE      = 15'b010000000000000,
        PH_REJECT    = 15'b100000000000000
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] name_byte;
        logic       found;
        logic       last_of_run;
    } result_t;

endpackage

[rtl/tsni_if.sv]
// Valid/ready channel interfaces for record bytes and extraction results.
interface tsni_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tsni_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] name_byte;
    logic       found;
    logic       last_of_run;

    modport source (output valid, output kind, output name_byte, output found,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input name_byte, input found,
                    input last_of_run, output ready);
endinterface

[rtl/tls_client_hello_sni_extractor.sv]
// TLS Client Hello server-name extractor, top level.
//
// bytes:   one record byte per transaction, last_byte set on the packet's final byte.
// results: hostname bytes (kind 0) as they arrive, then one verdict (kind 1)
//          on the last byte; found says whether a complete server name was taken.
// Each accepted byte is parsed in the cycle it is accepted, against the parser
// state registers; its results enter a four-entry result queue, which registers
// them and offers them in order. A byte yields zero, one or two results.
// Throughput: one byte per cycle; ready is high while at most two results
// are queued, so the queue absorbs the extra verdict of a final name byte.
// A byte that yields two results hands them out one after the other.
// When the receiver stalls, results collect in the queue and ready drops once
// more than two are waiting; nothing is dropped.
// Reset: parser returns to the header check at byte zero, queue empties.
// After each packet's last byte the parser returns to that same state.
module tls_client_hello_sni_extractor
    import tsni_pkg::*;
#(
    parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    tsni_in_if.sink         bytes,
    tsni_out_if.source      results
);

    localparam int unsigned PW = POSITION_BITS;
    localparam int unsigned PE = POSITION_BITS + 1;
    localparam int unsigned QA = $clog2(RESULT_DEPTH);
    localparam logic [PW-1:0] POS_MAX = '1;
    localparam logic [PE-1:0] POS_MAX_E = {1'b0, POS_MAX};

    phase_t          phase_reg, phase_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [PW-1:0]   bnd_reg, bnd_next;
    logic [PW-1:0]   ext_end_reg, ext_end_next;
    logic [7:0]      held_reg, held_next;
    logic [15:0]     left_reg, left_next;
    logic            accepted_reg, accepted_next;

    result_t         queue_reg [RESULT_DEPTH];
    logic [QA-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QA-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QA:0]     count_reg, count_next;

    logic            acc;
    logic            pop;
    logic [7:0]      b;
    logic [15:0]     b16;
    logic [PE-1:0]   pos_e;
    logic [PE-1:0]   ext_e;
    logic [PE-1:0]   sum_v;
    logic            at_bnd;
    logic            do_go;
    logic [PE-1:0]   go_target;
    phase_t          go_phase;
    logic            emit_name;
    logic            found_v;
    logic [1:0]      push_n;
    result_t         res0, res1;
    result_t         head;

    assign acc   = bytes.valid && bytes.ready;
    assign pop   = results.valid && results.ready;
    assign b     = bytes.data_byte;
    assign b16   = {held_reg, bytes.data_byte};
    assign pos_e = {1'b0, pos_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        bnd_next      = bnd_reg;
        ext_end_next  = ext_end_reg;
        held_next     = held_reg;
        left_next     = left_reg;
        accepted_next = accepted_reg;
        at_bnd        = (pos_reg == bnd_reg);
        do_go         = 1'b0;
        go_target     = '0;
        go_phase      = phase_reg;
        emit_name     = 1'b0;
        found_v       = 1'b0;
        sum_v         = pos_e + PE'(1) + PE'(b16);
        ext_e         = {1'b0, ext_end_reg};

        if (acc)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == '0 && b != CONTENT_HANDSHAKE)
                    begin
                        phase_next = PH_REJECT;
                    end
                    else if (pos_reg == PW'(REC_HEADER_LEN) && b != HS_CLIENT_HELLO)
                    begin
                        phase_next = PH_REJECT;
                    end
                    else if (pos_reg == PW'(SESSION_ID_POS))
                    begin
                        do_go     = 1'b1;
                        go_target = pos_e + PE'(1) + PE'(b);
                        go_phase  = PH_CIPHER_HI;
                    end
                end
                PH_NAME:
                begin
                    emit_name = 1'b1;
                    left_next = left_reg - 16'd1;
                    if (left_next == '0)
                    begin
                        accepted_next = 1'b1;
                        phase_next    = PH_DONE;
                    end
                end
                PH_CIPHER_HI, PH_EXT_HI, PH_TYPE_HI, PH_LEN_HI, PH_NAME_HI:
                begin
                    if (at_bnd)
                    begin
                        held_next = b;
                        do_go     = 1'b1;
                        go_target = pos_e + PE'(1);
                        go_phase  = phase_t'({phase_reg[13:0], 1'b0});
                    end
                end
                PH_CIPHER_LO:
                begin
                    if (at_bnd)
                    begin
                        do_go     = 1'b1;
                        go_target = sum_v;
                        go_phase  = PH_COMP_LEN;
                    end
                end
                PH_COMP_LEN:
                begin
                    if (at_bnd)
                    begin
                        do_go     = 1'b1;
                        go_target = pos_e + PE'(1) + PE'(b);
                        go_phase  = PH_EXT_HI;
                    end
                end
                PH_EXT_LO:
                begin
                    if (at_bnd)
                    begin
                        if (sum_v > POS_MAX_E)
                        begin
                            phase_next = PH_REJECT;
                        end
                        else
                        begin
                            ext_end_next = sum_v[PW-1:0];
                            if (pos_e + PE'(1) + PE'(EXT_HEADER_LEN) > sum_v)
                            begin
                                phase_next = PH_REJECT;
                            end
                            else
                            begin
                                do_go     = 1'b1;
                                go_target = pos_e + PE'(1);
                                go_phase  = PH_TYPE_HI;
                            end
                        end
                    end
                end
                PH_TYPE_LO:
                begin
                    if (at_bnd)
                    begin
                        if (b16 == EXT_SERVER_NAME)
                        begin
                            if (pos_e + PE'(SNI_MIN_END_OFS) > ext_e)
                            begin
                                phase_next = PH_REJECT;
                            end
                            else
                            begin
                                do_go     = 1'b1;
                                go_target = pos_e + PE'(SNI_NAME_LEN_OFS);
                                go_phase  = PH_NAME_HI;
                            end
                        end
                        else
                        begin
                            do_go     = 1'b1;
                            go_target = pos_e + PE'(1);
                            go_phase  = PH_LEN_HI;
                        end
                    end
                end
                PH_LEN_LO:
                begin
                    if (at_bnd)
                    begin
                        if (sum_v + PE'(EXT_HEADER_LEN) > ext_e)
                        begin
                            phase_next = PH_REJECT;
                        end
                        else
                        begin
                            do_go     = 1'b1;
                            go_target = sum_v;
                            go_phase  = PH_TYPE_HI;
                        end
                    end
                end
                PH_NAME_LO:
                begin
                    if (at_bnd)
                    begin
                        if (b16 == '0 || sum_v > ext_e)
                        begin
                            phase_next = PH_REJECT;
                        end
                        else
                        begin
                            left_next  = b16;
                            phase_next = PH_NAME;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (do_go)
            begin
                if (go_target >= POS_MAX_E)
                begin
                    phase_next = PH_REJECT;
                end
                else
                begin
                    bnd_next   = go_target[PW-1:0];
                    phase_next = go_phase;
                end
            end

            found_v = accepted_next && ((pos_e + PE'(1)) >= {1'b0, ext_end_next});

            if (bytes.last_byte)
            begin
                phase_next    = PH_HEADER;
                pos_next      = '0;
                bnd_next      = '0;
                ext_end_next  = '0;
                held_next     = '0;
                left_next     = '0;
                accepted_next = 1'b0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + PW'(1);
            end
        end
    end

    always_comb
    begin
        res0   = '{kind: KIND_NAME, name_byte: b, found: 1'b0, last_of_run: 1'b1};
        res1   = '{kind: KIND_VERDICT, name_byte: 8'd0, found: found_v, last_of_run: 1'b1};
        push_n = 2'd0;
        if (acc)
        begin
            if (emit_name && bytes.last_byte)
            begin
                res0.last_of_run = 1'b0;
                push_n           = 2'd2;
            end
            else if (emit_name)
            begin
                push_n = 2'd1;
            end
            else if (bytes.last_byte)
            begin
                res0   = res1;
                push_n = 2'd1;
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QA'(push_n);
        rd_ptr_next = rd_ptr_reg + QA'(pop);
        count_next  = count_reg + (QA+1)'(push_n) - (QA+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            bnd_reg      <= '0;
            ext_end_reg  <= '0;
            held_reg     <= '0;
            left_reg     <= '0;
            accepted_reg <= 1'b0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            bnd_reg      <= bnd_next;
            ext_end_reg  <= ext_end_next;
            held_reg     <= held_next;
            left_reg     <= left_next;
            accepted_reg <= accepted_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QA'(1)] <= res1;
        end
    end

    assign head                = queue_reg[rd_ptr_reg];
    assign bytes.ready         = (count_reg <= (QA+1)'(RESULT_DEPTH - 2));
    assign results.valid       = (count_reg != '0);
    assign results.kind        = head.kind;
    assign results.name_byte   = head.name_byte;
    assign results.found       = head.found;
    assign results.last_of_run = head.last_of_run;

endmodule

[rtl/tsni_checker.sv]
// Port-level assertions for the TLS server-name extractor, bound to the top level.
`include "assert_macros.svh"

module tsni_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_kind,
    input logic [7:0] out_name_byte,
    input logic       out_found,
    input logic       out_last_of_run
);

    `TSNI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_kind, out_name_byte, out_found, out_last_of_run}))
    `TSNI_ASSERT_IMP(a_verdict_shape, clk, rst_n, out_valid && out_kind, out_last_of_run && out_name_byte == 8'd0)
    `TSNI_ASSERT_IMP(a_found_in_verdict, clk, rst_n, out_valid && out_found, out_kind)
    `TSNI_ASSERT_NXT(a_verdict_follows, clk, rst_n, out_valid && out_ready && !out_kind && !out_last_of_run, out_valid && out_kind)

endmodule

bind tls_client_hello_sni_extractor tsni_checker u_tsni_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .out_kind        (results.kind),
    .out_name_byte   (results.name_byte),
    .out_found       (results.found),
    .out_last_of_run (results.last_of_run)
);
